// ===== rtl/core/smdc_pkg.sv =====
// shared constants and state codes for the sliding median deviation cost block
package smdc_pkg;
  localparam int IN_W   = 32;
  localparam int CFG_W  = 9;
  localparam int COST_W = 40;
  localparam int OUT_W  = 48;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_PROC = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  typedef logic [2:0] state_t;
endpackage

// ===== rtl/core/sliding_median_deviation_cost.sv =====
// top level: sliding window median deviation cost with sorted ping-pong merge pass
// each sample runs a pass: READ and PROC for every held entry, one more PROC when the new sample
// sorts ahead of a held one, then TAIL, CALC and, once the window is full, OUT
// throughput: one sample per pass; in_tready is low until the pass ends and while cfg_wr_en is high
// a finished result waits in the output register while the next sample is taken
// reset (synchronous, rst_n low) empties the window and sets the window size to 1
module sliding_median_deviation_cost #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [smdc_pkg::IN_W-1:0]  in_tdata,   // [31:0] sample
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [smdc_pkg::OUT_W-1:0] out_tdata,  // [39:0] cost, upper bits zero
  input  logic                       cfg_wr_en,
  input  logic [smdc_pkg::CFG_W-1:0] cfg_wr_data
);
  import smdc_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = AW + 1;
  localparam int SB = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int TW = SB + AW + 3;
  localparam int DEPTH = 1 << AW;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      size_r, size_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  bank_r, bank_nxt;
  logic [CW-1:0]         rd_r, rd_nxt;
  logic [CW-1:0]         wr_r, wr_nxt;
  logic                  rem_r, rem_nxt;
  logic                  ins_r, ins_nxt;
  logic signed [SB-1:0]  x_r, x_nxt;
  logic signed [SB-1:0]  med_r, med_nxt;
  logic signed [TW-1:0]  lsum_r, lsum_nxt;
  logic signed [TW-1:0]  usum_r, usum_nxt;
  logic signed [TW-1:0]  total_r, total_nxt;
  logic                  ovld_r, ovld_nxt;
  logic [COST_W-1:0]     odat_r, odat_nxt;

  logic signed [SB-1:0]  hist_mem [DEPTH];
  logic signed [SB-1:0]  sort_mem [2*DEPTH];
  logic signed [SB-1:0]  old_q, srd_q;

  logic [CW-1:0]         n_eff;
  logic [CW:0]           low_cnt;
  logic                  accept;
  logic                  emit_en;
  logic signed [SB-1:0]  emit_val;
  logic signed [TW-1:0]  emit_ext;
  logic signed [63:0]    total_64;

  always_comb begin
    if (size_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(size_r) > WINDOW_MAX) begin
      n_eff = CW'(WINDOW_MAX);
    end else begin
      n_eff = CW'(size_r);
    end
  end

  assign low_cnt   = ({1'b0, n_eff} + (CW+1)'(1)) >> 1;
  assign in_tready = (state_r == S_IDLE) && !cfg_wr_en;
  assign accept    = in_tvalid && in_tready;
  assign emit_ext  = {{(TW-SB){emit_val[SB-1]}}, emit_val};
  assign total_64  = {{(64-TW){total_r[TW-1]}}, total_r};

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    bank_nxt  = bank_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    rem_nxt   = rem_r;
    ins_nxt   = ins_r;
    x_nxt     = x_r;
    med_nxt   = med_r;
    lsum_nxt  = lsum_r;
    usum_nxt  = usum_r;
    total_nxt = total_r;
    ovld_nxt  = ovld_r && !out_tready;
    odat_nxt  = odat_r;
    emit_en   = 1'b0;
    emit_val  = x_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_wr_en) begin
          size_nxt = cfg_wr_data;
          fill_nxt = '0;
          ptr_nxt  = '0;
          lsum_nxt = '0;
          usum_nxt = '0;
        end else if (accept) begin
          x_nxt    = in_tdata[SB-1:0];
          rem_nxt  = (fill_r >= n_eff);
          ins_nxt  = 1'b1;
          rd_nxt   = '0;
          wr_nxt   = '0;
          lsum_nxt = '0;
          usum_nxt = '0;
          ptr_nxt  = (({1'b0, ptr_r} + CW'(1)) >= n_eff) ? '0 : ptr_r + AW'(1);
          state_nxt = (fill_r != '0) ? S_READ : S_TAIL;
        end
      end
      S_READ: begin
        state_nxt = S_PROC;
      end
      S_PROC: begin
        // drop the leaving sample once, slot the new one before the first larger entry
        if (rem_r && srd_q == old_q) begin
          rem_nxt = 1'b0;
          rd_nxt  = rd_r + CW'(1);
          state_nxt = (rd_r + CW'(1) == fill_r) ? S_TAIL : S_READ;
        end else if (ins_r && srd_q > x_r) begin
          emit_en  = 1'b1;
          emit_val = x_r;
          ins_nxt  = 1'b0;
        end else begin
          emit_en  = 1'b1;
          emit_val = srd_q;
          rd_nxt   = rd_r + CW'(1);
          state_nxt = (rd_r + CW'(1) == fill_r) ? S_TAIL : S_READ;
        end
      end
      S_TAIL: begin
        if (ins_r) begin
          emit_en  = 1'b1;
          emit_val = x_r;
          ins_nxt  = 1'b0;
        end
        fill_nxt  = (fill_r >= n_eff) ? fill_r : fill_r + CW'(1);
        bank_nxt  = !bank_r;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        total_nxt = usum_r - lsum_r +
                    (n_eff[0] ? {{(TW-SB){med_r[SB-1]}}, med_r} : TW'(0));
        state_nxt = (fill_r == n_eff) ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt = 1'b1;
          if (total_64 < 64'sd0) begin
            odat_nxt = '0;
          end else if (total_64 > $signed({24'd0, {COST_W{1'b1}}})) begin
            odat_nxt = '1;
          end else begin
            odat_nxt = total_64[COST_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit_en) begin
      wr_nxt = wr_r + CW'(1);
      if ({1'b0, wr_r} < low_cnt) begin
        lsum_nxt = lsum_r + emit_ext;
      end else begin
        usum_nxt = usum_r + emit_ext;
      end
      if ({1'b0, wr_r} + (CW+1)'(1) == low_cnt) begin
        med_nxt = emit_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= CFG_W'(1);
      fill_r  <= '0;
      ptr_r   <= '0;
      bank_r  <= 1'b0;
      rd_r    <= '0;
      wr_r    <= '0;
      rem_r   <= 1'b0;
      ins_r   <= 1'b0;
      lsum_r  <= '0;
      usum_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      bank_r  <= bank_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      rem_r   <= rem_nxt;
      ins_r   <= ins_nxt;
      lsum_r  <= lsum_nxt;
      usum_r  <= usum_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    med_r   <= med_nxt;
    total_r <= total_nxt;
    odat_r  <= odat_nxt;
  end

  // history ring: old entry is read out as the new one overwrites it
  always_ff @(posedge clk) begin
    if (accept) begin
      old_q <= hist_mem[ptr_r];
      hist_mem[ptr_r] <= in_tdata[SB-1:0];
    end
  end

  // sorted window, two banks: read current bank, merged result goes to the other
  always_ff @(posedge clk) begin
    srd_q <= sort_mem[{bank_r, rd_r[AW-1:0]}];
    if (emit_en) begin
      sort_mem[{!bank_r, wr_r[AW-1:0]}] <= emit_val;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {(OUT_W-COST_W)'(0), odat_r};
endmodule

// ===== rtl/core/smdc_checker.sv =====
// port-level checks for the sliding median deviation cost block
module smdc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [smdc_pkg::OUT_W-1:0] out_tdata
);
  import smdc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample taken during a pass");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:COST_W] == '0)
    else $error("cost padding not zero");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind sliding_median_deviation_cost smdc_checker u_smdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/tb.sv =====
// testbench for the sliding window median deviation cost block
module tb;
  import smdc_pkg::*;

  localparam int WIN_MAX    = 256;
  localparam int IDLE_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;

  sliding_median_deviation_cost DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // window mirror
  longint            arrival_ring [WIN_MAX];
  longint            ordered_win [$];
  int                held_cnt;
  int                ring_slot;
  int                win_len;
  logic [COST_W-1:0] cost_queue [$];

  bit idle_en = 1'b1;
  int errors = 0;
  int samples_sent = 0;
  int costs_checked = 0;
  int cfg_writes = 0;
  int idle_cnt = 0;

  function automatic void window_clear();
    ordered_win.delete();
    held_cnt = 0;
    ring_slot = 0;
  endfunction

  function automatic void apply_size(logic [CFG_W-1:0] v);
    if (v == 0) win_len = 1;
    else if (int'(v) > WIN_MAX) win_len = WIN_MAX;
    else win_len = int'(v);
    window_clear();
  endfunction

  // slide one sample into the window, queue the cost once full
  function automatic void push_sample(logic [IN_W-1:0] raw);
    longint x;
    longint lo_sum;
    longint hi_sum;
    longint total;
    int lo_cnt;
    int k;
    x = longint'($signed(raw));
    if (ring_slot >= win_len) ring_slot = 0;
    if (held_cnt >= win_len) begin
      for (k = 0; k < ordered_win.size(); k++) begin
        if (ordered_win[k] == arrival_ring[ring_slot]) begin
          ordered_win.delete(k);
          break;
        end
      end
      held_cnt--;
    end
    arrival_ring[ring_slot] = x;
    ring_slot = (ring_slot + 1 >= win_len) ? 0 : ring_slot + 1;
    k = ordered_win.size();
    while (k > 0 && ordered_win[k-1] > x) k--;
    ordered_win.insert(k, x);
    held_cnt++;
    if (held_cnt < win_len) return;
    lo_cnt = (win_len + 1) / 2;
    lo_sum = 0;
    hi_sum = 0;
    for (k = 0; k < win_len; k++) begin
      if (k < lo_cnt) lo_sum += ordered_win[k];
      else hi_sum += ordered_win[k];
    end
    total = hi_sum - lo_sum;
    if (win_len % 2 == 1) total += ordered_win[lo_cnt-1];
    if (total < 0) total = 0;
    if (total > 64'hFF_FFFF_FFFF) total = 64'hFF_FFFF_FFFF;
    cost_queue.insert(cost_queue.size(), total[COST_W-1:0]);
  endfunction

  task automatic send_sample(logic [IN_W-1:0] v);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    push_sample(v);
    samples_sent++;
  endtask

  // stop sending and wait until every queued cost has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cost_queue.size() != 0) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] v);
    drain();
    // a sample may still be in a merge pass without producing a cost
    repeat (2 * WIN_MAX + 20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_size(v);
    cfg_writes++;
  endtask

  // receiver side backpressure in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_en) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [COST_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cost_queue.size() == 0) begin
        $error("unexpected cost transaction %0d", out_tdata[COST_W-1:0]);
        errors++;
      end else begin
        want = cost_queue.pop_front();
        if (out_tdata[COST_W-1:0] !== want) begin
          $error("cost: expected %0d, actual %0d", want, out_tdata[COST_W-1:0]);
          errors++;
        end
        costs_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic test_reset_size();
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
  endtask

  task automatic test_odd_with_duplicates();
    set_size(3);
    send_sample(5);
    send_sample(5);
    send_sample(5);
    send_sample(-7);
    send_sample(100);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(100);
  endtask

  task automatic test_even_extremes();
    set_size(2);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(0);
  endtask

  task automatic test_zero_size();
    set_size(0);
    send_sample(32'h1234_5678);
    send_sample(32'hDEAD_BEEF);
    send_sample(0);
  endtask

  task automatic test_refill_after_write();
    set_size(4);
    send_sample(10);
    send_sample(-20);
    set_size(4);
    repeat (5) send_sample($urandom_range(0, 40) - 20);
  endtask

  task automatic test_oversize();
    set_size(511);
    repeat (270) send_sample($urandom);
  endtask

  task automatic test_random_phases();
    int phase_len;
    int sz;
    int narrow;
    int budget;
    budget = 900;
    while (budget > 0) begin
      sz = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      set_size(CFG_W'(sz));
      narrow = $urandom_range(0, 1);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        if ($urandom_range(0, 60) == 0) drain();
        // narrow range gives plenty of equal samples
        if (narrow) send_sample($urandom_range(0, 16) - 8);
        else send_sample($urandom);
      end
      budget -= phase_len;
    end
  endtask

  task automatic test_full_rate();
    set_size(5);
    idle_en = 1'b0;
    repeat (60) send_sample($urandom);
  endtask

  initial begin
    apply_size(1);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_odd_with_duplicates();
    test_even_extremes();
    test_zero_size();
    test_refill_after_write();
    test_oversize();
    test_random_phases();
    test_full_rate();
    drain();
    repeat (2 * WIN_MAX + 20) @(posedge clk);
    $display("covered %0d samples, %0d costs checked, %0d window size writes",
             samples_sent, costs_checked, cfg_writes);
    $display("window sizes 0, 1 through 64 and above the maximum, with backpressure");
    if (errors == 0 && cost_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/smdc_pkg.sv
rtl/core/sliding_median_deviation_cost.sv
rtl/core/smdc_checker.sv
test/tb.sv
